// ----- rtl/fdtd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdtd_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SHIFT_W = PROD_W - FRAC_W;
    localparam int NSTORE = 16;
    localparam int CFG_DATA_W = 7;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [1:0] CFG_GRID_MODE = 2'd0;
    localparam logic [1:0] CFG_SIZE_X    = 2'd1;
    localparam logic [1:0] CFG_SIZE_Y    = 2'd2;

    localparam logic [3:0] SEL_BX     = 4'd0;
    localparam logic [3:0] SEL_BY     = 4'd1;
    localparam logic [3:0] SEL_HX     = 4'd2;
    localparam logic [3:0] SEL_HY     = 4'd3;
    localparam logic [3:0] SEL_DZ     = 4'd4;
    localparam logic [3:0] SEL_EZ     = 4'd5;
    localparam logic [3:0] SEL_CHXH   = 4'd6;
    localparam logic [3:0] SEL_CHXE   = 4'd7;
    localparam logic [3:0] SEL_CHYH   = 4'd8;
    localparam logic [3:0] SEL_CHYE   = 4'd9;
    localparam logic [3:0] SEL_CEZE   = 4'd10;
    localparam logic [3:0] SEL_CEZH   = 4'd11;
    localparam logic [3:0] SEL_MU_XX  = 4'd12;
    localparam logic [3:0] SEL_MU_YY  = 4'd13;
    localparam logic [3:0] SEL_EPS_ZZ = 4'd14;
    // Slot 15 is not host visible; it holds the curl of H.
    localparam logic [3:0] SEL_CURL   = 4'd15;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PASS,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CALC,
        ST_MUL0,
        ST_MUL0P,
        ST_MUL1P,
        ST_CURL,
        ST_DIV,
        ST_DIVP,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PASS_BX,
        PASS_BY,
        PASS_HX,
        PASS_HY,
        PASS_CURL,
        PASS_DZ,
        PASS_EZ
    } pass_t;

    function automatic pass_t next_pass(input pass_t p);
        pass_t r;
        case (p)
            PASS_BX:   r = PASS_BY;
            PASS_BY:   r = PASS_HX;
            PASS_HX:   r = PASS_HY;
            PASS_HY:   r = PASS_CURL;
            PASS_CURL: r = PASS_DZ;
            default:   r = PASS_EZ;
        endcase
        return r;
    endfunction

    function automatic word_t word_mag(input word_t v);
        return v[WORD_W-1] ? word_t'(~v + word_t'(1)) : v;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        word_t s;
        s = a + b;
        if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1])
            s = a[WORD_W-1] ? WORD_MIN : WORD_MAX;
        return s;
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        word_t d;
        d = a - b;
        if (a[WORD_W-1] != b[WORD_W-1] && d[WORD_W-1] != a[WORD_W-1])
            d = a[WORD_W-1] ? WORD_MIN : WORD_MAX;
        return d;
    endfunction

    // Drops the fraction bits of a product magnitude, applies the sign and saturates.
    function automatic word_t mul_pack(input logic [PROD_W-1:0] p, input logic neg);
        logic [SHIFT_W-1:0] sh;
        word_t r;
        sh = p[PROD_W-1:FRAC_W];
        if (neg) begin
            if (sh > SHIFT_W'(WORD_MIN))
                r = WORD_MIN;
            else
                r = ~sh[WORD_W-1:0] + word_t'(1);
        end
        else begin
            if (sh > SHIFT_W'(WORD_MAX))
                r = WORD_MAX;
            else
                r = sh[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic word_t div_pack(input word_t q, input logic neg);
        word_t r;
        if (neg)
            r = (q > WORD_MIN) ? WORD_MIN : (~q + word_t'(1));
        else
            r = (q > WORD_MAX) ? WORD_MAX : q;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fdtd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/fdtd_tmz_field_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Word
// cmd       in         cmd_valid / cmd_stall    cmd, array_sel, cell_x, cell_y, write_value
// rsp       out        rsp_valid / rsp_stall    read_value, step_done
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A write goes into its store in the cycle it is accepted; a read passes through the store's
// read register and rsp_value_reg. A step runs one cell at a time through the shared memory
// read sequence and datapath: B and D cells use two multiplies, curl cells a subtraction,
// H and E cells the radix-2 divider unless the quotient saturates. After reset the six field
// stores are cleared one entry per cycle while cmd is stalled; cmd is also stalled while a
// response is held by rsp_stall. Configuration writes are taken at any time.

module fdtd_tmz_field_update import fdtd_pkg::*; #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire logic        [1:0]            cmd,
    input  wire logic        [3:0]            array_sel,
    input  wire logic        [5:0]            cell_x,
    input  wire logic        [5:0]            cell_y,
    input  wire logic signed [WORD_W-1:0]     write_value,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic signed      [WORD_W-1:0]     read_value,
    output logic                              step_done,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [1:0]            cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_X * MAX_Y;
    localparam int AW = $clog2(DEPTH);
    localparam int XB = $clog2(MAX_X);
    localparam int YB = $clog2(MAX_Y);

    state_t state_reg, state_next;
    pass_t  pass_reg;

    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] size_x_reg;
    logic [CFG_DATA_W-1:0] size_y_reg;

    logic [XB-1:0] m_reg;
    logic [YB-1:0] n_reg;
    logic [AW-1:0] clr_reg;
    logic [4:0]    cnt_reg;
    logic          rsp_valid_reg;
    word_t         rsp_value_reg;
    logic          rsp_done_reg;
    logic [3:0]    sel_reg;
    logic          ok_reg;

    word_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    word_t g_reg, h_reg, p1_reg, res_reg;
    logic [PROD_W-1:0] mp_reg;
    logic              mneg_reg;
    word_t rem_reg, den_reg, q_reg, dsh_reg;
    logic  dneg_reg;

    logic [XB-1:0] lx, mend;
    logic [YB-1:0] ly, nend, rs, pr;
    logic          mstart_one, pass_on, pass_empty, last_cell;
    logic [AW-1:0] host_addr, rd_addr, wr_addr;
    word_t         wr_data;
    logic [NSTORE-1:0] we;
    word_t         mem_rd [NSTORE];
    logic          host_ok, cmd_acc;
    logic [3:0]    target;
    word_t         num_mag, den_mag, diff;
    logic [WORD_W:0] rem_shift;

    function automatic logic [AW-1:0] cell_addr(input logic [XB-1:0] x, input logic [YB-1:0] y);
        return AW'(y) * AW'(MAX_X) + AW'(x);
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < NSTORE; gi++)
        begin : g_store
            fdtd_ram #(
                .WIDTH (WORD_W),
                .DEPTH (DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (we[gi]),
                .waddr (wr_addr),
                .wdata (wr_data),
                .raddr (rd_addr),
                .rdata (mem_rd[gi])
            );
        end
    endgenerate

    // Effective last column and row indexes, with the sizes clamped to the grid.
    always_comb
    begin
        if (size_x_reg < CFG_DATA_W'(2))
            lx = XB'(1);
        else if (32'(size_x_reg) > MAX_X)
            lx = XB'(MAX_X - 1);
        else
            lx = XB'(size_x_reg - CFG_DATA_W'(1));
        if (size_y_reg < CFG_DATA_W'(2))
            ly = YB'(1);
        else if (32'(size_y_reg) > MAX_Y)
            ly = YB'(MAX_Y - 1);
        else
            ly = YB'(size_y_reg - CFG_DATA_W'(1));
    end

    always_comb
    begin
        mstart_one = (pass_reg == PASS_CURL) || (pass_reg == PASS_DZ)
                     || (pass_reg == PASS_EZ && !mode_reg);
        if (pass_reg inside {PASS_BY, PASS_HY, PASS_CURL, PASS_DZ}
            || (pass_reg == PASS_EZ && !mode_reg))
            mend = lx - XB'(1);
        else
            mend = lx;
        case (pass_reg)
            PASS_BX, PASS_HX: nend = ly - YB'(1);
            PASS_CURL:        nend = ly;
            default:          nend = mode_reg ? ly : '0;
        endcase
        pass_on = mode_reg || (pass_reg inside {PASS_BY, PASS_HY, PASS_DZ, PASS_EZ});
        pass_empty = mstart_one && (mend == '0);
        last_cell = (n_reg == nend) && (m_reg == mend);
        // The top row of the curl wraps to row 0; row 0 looks back to the next-to-last row.
        rs = (n_reg == ly) ? '0 : n_reg;
        pr = (rs == '0) ? ly - YB'(1) : rs - YB'(1);
        case (pass_reg)
            PASS_BX:   target = SEL_BX;
            PASS_BY:   target = SEL_BY;
            PASS_HX:   target = SEL_HX;
            PASS_HY:   target = SEL_HY;
            PASS_CURL: target = SEL_CURL;
            PASS_DZ:   target = SEL_DZ;
            default:   target = SEL_EZ;
        endcase
    end

    always_comb
    begin
        case (pass_reg)
            PASS_BX, PASS_BY: diff = sat_sub(e_reg, d_reg);
            PASS_DZ:          diff = mode_reg ? d_reg : sat_sub(d_reg, e_reg);
            default:          diff = sat_sub(a_reg, e_reg);
        endcase
        num_mag = word_mag(a_reg);
        den_mag = word_mag(b_reg);
        rem_shift = {rem_reg, dsh_reg[WORD_W-1]};
    end

    assign host_addr = cell_addr(XB'(cell_x), YB'(cell_y));
    assign host_ok = (32'(cell_x) < MAX_X) && (32'(cell_y) < MAX_Y) && (array_sel != SEL_CURL);
    assign cmd_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign cmd_acc = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        rd_addr = cell_addr(m_reg, n_reg);
        wr_addr = cell_addr(m_reg, n_reg);
        wr_data = res_reg;
        we = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_addr = clr_reg;
                wr_data = '0;
                for (int i = 0; i <= int'(SEL_EZ); i++)
                begin
                    we[i] = 1'b1;
                end
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                rd_addr = host_addr;
                wr_addr = host_addr;
                wr_data = $unsigned(write_value);
                if (cmd_acc)
                begin
                    case (cmd)
                        CMD_WRITE:
                        begin
                            if (host_ok)
                                we[array_sel] = 1'b1;
                        end
                        CMD_READ: state_next = ST_READ;
                        CMD_STEP: state_next = ST_PASS;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: state_next = ST_IDLE;
            ST_PASS:
            begin
                if (!pass_on || pass_empty)
                    state_next = (pass_reg == PASS_EZ) ? ST_DONE : ST_PASS;
                else
                    state_next = ST_RD0;
            end
            ST_RD0:
            begin
                if (pass_reg == PASS_CURL)
                    rd_addr = cell_addr(m_reg, rs);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                case (pass_reg)
                    PASS_BX:   rd_addr = cell_addr(m_reg, n_reg + YB'(1));
                    PASS_BY:   rd_addr = cell_addr(m_reg + XB'(1), n_reg);
                    PASS_CURL: rd_addr = cell_addr(m_reg - XB'(1), rs);
                    PASS_DZ:   rd_addr = cell_addr(m_reg - XB'(1), n_reg);
                    default:   rd_addr = cell_addr(m_reg, n_reg);
                endcase
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                rd_addr = cell_addr(m_reg, pr);
                state_next = ST_RD3;
            end
            ST_RD3: state_next = ST_CALC;
            ST_CALC:
            begin
                case (pass_reg)
                    PASS_HX, PASS_HY, PASS_EZ:
                    begin
                        if (den_mag == '0 || (num_mag >> FRAC_W) >= den_mag)
                            state_next = ST_WB;
                        else
                            state_next = ST_DIV;
                    end
                    PASS_CURL: state_next = ST_CURL;
                    default:   state_next = ST_MUL0;
                endcase
            end
            ST_MUL0:  state_next = ST_MUL0P;
            ST_MUL0P: state_next = ST_MUL1P;
            ST_MUL1P: state_next = ST_WB;
            ST_CURL:  state_next = ST_WB;
            ST_DIV:
            begin
                if (cnt_reg == 5'(WORD_W - 1))
                    state_next = ST_DIVP;
            end
            ST_DIVP: state_next = ST_WB;
            ST_WB:
            begin
                we[target] = 1'b1;
                if (!last_cell)
                    state_next = ST_RD0;
                else if (pass_reg == PASS_EZ)
                    state_next = ST_DONE;
                else
                    state_next = ST_PASS;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pass_reg <= PASS_BX;
            m_reg <= '0;
            n_reg <= '0;
            clr_reg <= '0;
            cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
            mode_reg <= 1'b1;
            size_x_reg <= CFG_DATA_W'(64);
            size_y_reg <= CFG_DATA_W'(64);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_MODE: mode_reg <= cfg_data[0];
                    CFG_SIZE_X:    size_x_reg <= cfg_data;
                    CFG_SIZE_Y:    size_y_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (state_reg == ST_READ || state_reg == ST_DONE)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + AW'(1);
                ST_IDLE:
                begin
                    if (cmd_acc && cmd == CMD_STEP)
                        pass_reg <= PASS_BX;
                end
                ST_PASS:
                begin
                    if (!pass_on || pass_empty)
                    begin
                        pass_reg <= next_pass(pass_reg);
                    end
                    else
                    begin
                        m_reg <= mstart_one ? XB'(1) : '0;
                        n_reg <= '0;
                    end
                end
                ST_CALC: cnt_reg <= '0;
                ST_DIV:  cnt_reg <= cnt_reg + 5'(1);
                ST_WB:
                begin
                    if (n_reg == nend)
                    begin
                        n_reg <= '0;
                        m_reg <= m_reg + XB'(1);
                        if (m_reg == mend)
                            pass_reg <= next_pass(pass_reg);
                    end
                    else
                    begin
                        n_reg <= n_reg + YB'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sel_reg <= array_sel;
                ok_reg <= host_ok;
            end
            ST_READ:
            begin
                rsp_value_reg <= ok_reg ? mem_rd[sel_reg] : '0;
                rsp_done_reg <= 1'b0;
            end
            ST_DONE:
            begin
                rsp_value_reg <= '0;
                rsp_done_reg <= 1'b1;
            end
            ST_RD1:
            begin
                case (pass_reg)
                    PASS_BX:
                    begin
                        a_reg <= mem_rd[SEL_CHXH];
                        b_reg <= mem_rd[SEL_BX];
                        c_reg <= mem_rd[SEL_CHXE];
                        d_reg <= mem_rd[SEL_EZ];
                    end
                    PASS_BY:
                    begin
                        a_reg <= mem_rd[SEL_CHYH];
                        b_reg <= mem_rd[SEL_BY];
                        c_reg <= mem_rd[SEL_CHYE];
                        d_reg <= mem_rd[SEL_EZ];
                    end
                    PASS_HX:
                    begin
                        a_reg <= mem_rd[SEL_BX];
                        b_reg <= mem_rd[SEL_MU_XX];
                    end
                    PASS_HY:
                    begin
                        a_reg <= mem_rd[SEL_BY];
                        b_reg <= mem_rd[SEL_MU_YY];
                    end
                    PASS_CURL:
                    begin
                        a_reg <= mem_rd[SEL_HY];
                        c_reg <= mem_rd[SEL_HX];
                    end
                    PASS_DZ:
                    begin
                        a_reg <= mem_rd[SEL_CEZE];
                        b_reg <= mem_rd[SEL_DZ];
                        c_reg <= mem_rd[SEL_CEZH];
                        d_reg <= mode_reg ? mem_rd[SEL_CURL] : mem_rd[SEL_HY];
                    end
                    default:
                    begin
                        a_reg <= mem_rd[SEL_DZ];
                        b_reg <= mem_rd[SEL_EPS_ZZ];
                    end
                endcase
            end
            ST_RD2:
            begin
                e_reg <= (pass_reg == PASS_CURL || pass_reg == PASS_DZ)
                         ? mem_rd[SEL_HY] : mem_rd[SEL_EZ];
            end
            ST_RD3: f_reg <= mem_rd[SEL_HX];
            ST_CALC:
            begin
                g_reg <= diff;
                h_reg <= sat_sub(c_reg, f_reg);
                den_reg <= den_mag;
                dneg_reg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                rem_reg <= num_mag >> FRAC_W;
                dsh_reg <= num_mag << (WORD_W - FRAC_W);
                q_reg <= '0;
                // Division by zero (0/0 gives zero) and quotients past the word range saturate at once.
                if (den_mag == '0)
                    res_reg <= (num_mag == '0) ? '0 : (a_reg[WORD_W-1] ? WORD_MIN : WORD_MAX);
                else
                    res_reg <= (a_reg[WORD_W-1] ^ b_reg[WORD_W-1]) ? WORD_MIN : WORD_MAX;
            end
            ST_MUL0:
            begin
                mp_reg <= PROD_W'(word_mag(a_reg)) * PROD_W'(word_mag(b_reg));
                mneg_reg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
            end
            ST_MUL0P:
            begin
                p1_reg <= mul_pack(mp_reg, mneg_reg);
                mp_reg <= PROD_W'(word_mag(c_reg)) * PROD_W'(word_mag(g_reg));
                mneg_reg <= c_reg[WORD_W-1] ^ g_reg[WORD_W-1];
            end
            ST_MUL1P:
            begin
                if (pass_reg == PASS_BX)
                    res_reg <= sat_sub(p1_reg, mul_pack(mp_reg, mneg_reg));
                else
                    res_reg <= sat_add(p1_reg, mul_pack(mp_reg, mneg_reg));
            end
            ST_CURL: res_reg <= sat_sub(g_reg, h_reg);
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_reg <= word_t'(rem_shift - {1'b0, den_reg});
                    q_reg <= {q_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[WORD_W-1:0];
                    q_reg <= {q_reg[WORD_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg << 1;
            end
            ST_DIVP: res_reg <= div_pack(q_reg, dneg_reg);
            default: ;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_value = $signed(rsp_value_reg);
    assign step_done = rsp_done_reg;

endmodule

`default_nettype wire
